// ===== hw/rtl/bcr_pkg.sv =====
`default_nettype none

package bcr_pkg;

  localparam int unsigned MAX_LENGTH_DEF      = 65536;
  localparam int unsigned MAX_CHECKPOINTS_DEF = 1025;
  localparam int unsigned ALPHABET_SIZE       = 6;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned RATE_W = 17;

  localparam logic [RATE_W-1:0] RATE_LOW   = RATE_W'(64);
  localparam logic [RATE_W-1:0] RATE_HIGH  = RATE_W'(65536);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(128);

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR    = 2'd0,
    FN_APPEND   = 2'd1,
    FN_RANK_ONE = 2'd2,
    FN_RANK_ALL = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SYM   = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_NOT_BUILT = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [CODE_W-1:0] {
    SC_END = 3'd0,
    SC_A   = 3'd1,
    SC_C   = 3'd2,
    SC_G   = 3'd3,
    SC_N   = 3'd4,
    SC_T   = 3'd5
  } sym_code_e;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
  } sym_t;

  typedef logic [ALPHABET_SIZE-1:0][CNT_W-1:0] cnt_row_t;

  localparam logic [SYM_W-1:0] CH_END   = 8'h24;
  localparam logic [SYM_W-1:0] CH_A     = 8'h41;
  localparam logic [SYM_W-1:0] CH_C     = 8'h43;
  localparam logic [SYM_W-1:0] CH_G     = 8'h47;
  localparam logic [SYM_W-1:0] CH_N     = 8'h4E;
  localparam logic [SYM_W-1:0] CH_T     = 8'h54;
  localparam logic [SYM_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [SYM_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [SYM_W-1:0] CASE_OFS = 8'h20;

  // Maps an ASCII symbol, either case, onto the six-symbol alphabet.
  function automatic sym_t sym_code(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] c;
    sym_t             r;
    c = s;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      c = c - CASE_OFS;
    end
    r.ok   = 1'b1;
    r.code = SC_END;
    case (c)
      CH_END:  r.code = SC_END;
      CH_A:    r.code = SC_A;
      CH_C:    r.code = SC_C;
      CH_G:    r.code = SC_G;
      CH_N:    r.code = SC_N;
      CH_T:    r.code = SC_T;
      default: r.ok   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcr_cfg.sv =====
`default_nettype none

module bcr_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [bcr_pkg::RATE_W-1:0] rate_o
);
  import bcr_pkg::*;

  logic [RATE_W-1:0] rate_q, rate_d, wval;
  logic              wr_en, reg_sel;

  // One register; the upper address bit selects space beyond it.
  assign reg_sel = (paddr[2] == 1'b0);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign wval    = pwdata[RATE_W-1:0];
  assign pready  = 1'b1;

  always_comb begin
    rate_d = rate_q;
    if (wr_en) begin
      if (wval < RATE_LOW) begin
        rate_d = RATE_LOW;
      end else if (wval > RATE_HIGH) begin
        rate_d = RATE_HIGH;
      end else begin
        rate_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else begin
      rate_q <= rate_d;
    end
  end

  assign prdata = reg_sel ? 32'(rate_q) : 32'd0;
  assign rate_o = rate_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bcr_divider.sv =====
`default_nettype none

module bcr_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [bcr_pkg::POS_W-1:0] dividend_i,
  input  wire logic [bcr_pkg::POS_W-1:0] divisor_i,
  output logic                           done_o,
  output logic      [bcr_pkg::POS_W-1:0] quotient_o
);
  import bcr_pkg::*;

  localparam int unsigned STEP_W = $clog2(POS_W + 1);

  logic [POS_W-1:0]  rem_q, rem_d, quo_q, quo_d, div_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [POS_W:0]    trial;
  logic              fits;

  // One restoring step per cycle through a single subtractor.
  assign trial = {rem_q, quo_q[POS_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? POS_W'(trial - {1'b0, div_q}) : POS_W'(trial);
      quo_d  = {quo_q[POS_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(POS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bwt_checkpoint_rank.sv =====
`default_nettype none

// Occurrence-rank engine over a stored BWT string on the alphabet $ A C G N T.
// A clear item starts a build (latching the rate register), an append item
// stores one symbol, and rank items return one count or six counts (one per
// symbol, in code order, last on the sixth). Clear, append and every error
// give a single result. A rank query first runs the one-bit-per-cycle
// divider that finds the checkpoint (17 steps and its done register), then
// does the checkpoint start multiply and row read, loads the row, and scans
// one stored symbol per cycle through the symbol memory's single read port,
// then drains its read register and closes the scan; results then follow one
// per cycle while the output is accepted. The block takes no new item while a
// query is in progress. No clearing pass runs after reset.
module bwt_checkpoint_rank #(
  parameter int unsigned MAX_LENGTH      = bcr_pkg::MAX_LENGTH_DEF,
  parameter int unsigned MAX_CHECKPOINTS = bcr_pkg::MAX_CHECKPOINTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [bcr_pkg::FUNC_W-1:0] func_i,
  input  wire logic [bcr_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic [bcr_pkg::POS_W-1:0]  position_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [bcr_pkg::CNT_W-1:0]  count_o,
  output logic      [bcr_pkg::CODE_W-1:0] code_o,
  output logic      [bcr_pkg::STAT_W-1:0] status_o,
  output logic                            last_o
);
  import bcr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W  = $clog2(64'(MAX_LENGTH) + 64'd1);
  localparam int unsigned SCAN_W = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int unsigned CP_W   = $clog2(MAX_CHECKPOINTS);
  localparam int unsigned PROD_W = CP_W + RATE_W;
  localparam logic [CP_W-1:0] CP_LAST = CP_W'(MAX_CHECKPOINTS - 1);
  localparam logic [CODE_W-1:0] CODE_LAST = CODE_W'(ALPHABET_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL, S_LOAD, S_SCAN, S_EMIT
  } state_e;

  state_e            state_q;
  logic [RATE_W-1:0] cfg_rate, act_rate_q, phase_q, phase_nx;
  logic [LEN_W-1:0]  len_q;
  logic [CP_W-1:0]   cp_idx_q, cp_q, cp_sel;
  logic              built_q;
  cnt_row_t          run_q, run_inc, cnt_q;
  logic [POS_W-1:0]  pos_q;
  logic              one_q;
  logic [CODE_W-1:0] code_q, idx_q;
  logic [SCAN_W-1:0] p_q, start_q, pos_ext;
  logic              sv_q;
  logic              out_valid_q, last_q;
  logic [CNT_W-1:0]  count_q;
  logic [CODE_W-1:0] sym_id_q;
  status_e           status_q;

  logic              in_fire, out_free, out_set, issue, emit_last;
  func_e             fn;
  sym_t              sym;
  status_e           err;
  logic              div_start, div_done;
  logic [POS_W-1:0]  div_quo;
  logic [PROD_W-1:0] prod;

  logic              st_we;
  logic [CODE_W-1:0] st_rd_q;
  logic              cp_we;
  logic [CP_W-1:0]   cp_wa;
  cnt_row_t          cp_wd, cp_rd_q;

  logic [CODE_W-1:0] st_mem [MAX_LENGTH];
  cnt_row_t          cp_mem [MAX_CHECKPOINTS];

  bcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rate_o  (cfg_rate)
  );

  bcr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (position_i),
    .divisor_i  (act_rate_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign fn         = func_e'(func_i);
  assign sym        = sym_code(symbol_i);
  assign phase_nx   = phase_q + RATE_W'(1);
  assign pos_ext    = SCAN_W'(pos_q);
  assign issue      = (p_q < pos_ext) && (64'(p_q) < 64'(MAX_LENGTH));
  assign emit_last  = one_q || (idx_q == CODE_LAST);
  assign prod       = PROD_W'(cp_q) * PROD_W'(act_rate_q);
  assign cp_sel     = (32'(div_quo) >= 32'(CP_LAST)) ? CP_LAST : CP_W'(div_quo);

  always_comb begin
    run_inc           = run_q;
    run_inc[sym.code] = run_q[sym.code] + CNT_W'(1);
  end

  // Checks in the order the item type defines; ST_OK means the item proceeds.
  always_comb begin
    err = ST_OK;
    unique case (fn)
      FN_CLEAR: err = ST_OK;
      FN_APPEND: begin
        if (!built_q) begin
          err = ST_NOT_BUILT;
        end else if (!sym.ok) begin
          err = ST_BAD_SYM;
        end else if (64'(len_q) >= 64'(MAX_LENGTH)) begin
          err = ST_FULL;
        end
      end
      FN_RANK_ONE, FN_RANK_ALL: begin
        if (SCAN_W'(position_i) > SCAN_W'(len_q)) begin
          err = ST_BAD_POS;
        end else if (!built_q) begin
          err = ST_NOT_BUILT;
        end else if (fn == FN_RANK_ONE && !sym.ok) begin
          err = ST_BAD_SYM;
        end
      end
      default: err = ST_OK;
    endcase
  end

  assign div_start = in_fire && (err == ST_OK) &&
                     (fn == FN_RANK_ONE || fn == FN_RANK_ALL);
  assign st_we     = in_fire && (err == ST_OK) && (fn == FN_APPEND);
  // Every accepted item except a query that goes on to scan answers at once.
  assign out_set   = (in_fire && !div_start) || ((state_q == S_EMIT) && out_free);

  always_comb begin
    cp_we = 1'b0;
    cp_wa = '0;
    cp_wd = '0;
    if (in_fire && fn == FN_CLEAR) begin
      cp_we = 1'b1;
    end else if (st_we && phase_nx == act_rate_q && cp_idx_q != CP_LAST) begin
      cp_we = 1'b1;
      cp_wa = cp_idx_q + CP_W'(1);
      cp_wd = run_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[len_q[ADDR_W-1:0]] <= sym.code;
    end
    if (state_q == S_SCAN && issue) begin
      st_rd_q <= st_mem[p_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cp_we) begin
      cp_mem[cp_wa] <= cp_wd;
    end
    if (state_q == S_MUL) begin
      cp_rd_q <= cp_mem[cp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_rate_q  <= RATE_RESET;
      phase_q     <= '0;
      len_q       <= '0;
      cp_idx_q    <= '0;
      built_q     <= 1'b0;
      run_q       <= '0;
      pos_q       <= '0;
      one_q       <= 1'b0;
      code_q      <= '0;
      cp_q        <= '0;
      start_q     <= '0;
      cnt_q       <= '0;
      p_q         <= '0;
      idx_q       <= '0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      sym_id_q    <= '0;
      status_q    <= ST_OK;
    end else begin
      out_valid_q <= out_set || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            pos_q  <= position_i;
            one_q  <= (fn == FN_RANK_ONE);
            code_q <= sym.code;
            if (err != ST_OK) begin
              count_q     <= '0;
              sym_id_q    <= '0;
              status_q    <= err;
              last_q      <= 1'b1;
            end else if (fn == FN_CLEAR) begin
              act_rate_q  <= cfg_rate;
              phase_q     <= '0;
              len_q       <= '0;
              cp_idx_q    <= '0;
              built_q     <= 1'b1;
              run_q       <= '0;
              count_q     <= '0;
              sym_id_q    <= '0;
              status_q    <= ST_OK;
              last_q      <= 1'b1;
            end else if (fn == FN_APPEND) begin
              run_q <= run_inc;
              len_q <= len_q + LEN_W'(1);
              if (phase_nx == act_rate_q) begin
                phase_q <= '0;
                if (cp_idx_q != CP_LAST) begin
                  cp_idx_q <= cp_idx_q + CP_W'(1);
                end
              end else begin
                phase_q <= phase_nx;
              end
              count_q     <= run_inc[sym.code];
              sym_id_q    <= sym.code;
              status_q    <= ST_OK;
              last_q      <= 1'b1;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cp_q    <= cp_sel;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          start_q <= SCAN_W'(prod);
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          cnt_q   <= cp_rd_q;
          p_q     <= start_q;
          sv_q    <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // Reads are issued one per cycle; each read word is registered before its count is added.
          sv_q <= issue;
          if (issue) begin
            p_q <= p_q + SCAN_W'(1);
          end
          if (sv_q && st_rd_q <= CODE_LAST) begin
            cnt_q[st_rd_q] <= cnt_q[st_rd_q] + CNT_W'(1);
          end
          if (!issue && !sv_q) begin
            idx_q   <= one_q ? code_q : '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            count_q     <= cnt_q[idx_q];
            sym_id_q    <= idx_q;
            status_q    <= ST_OK;
            last_q      <= emit_last;
            if (emit_last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + CODE_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign code_o      = sym_id_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> p_q <= pos_ext)
    else $error("scan pointer passed the query position");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < act_rate_q)
    else $error("checkpoint phase reached the latched rate");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !in_ready_o)
    else $error("new item taken while a query is in progress");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |=> len_q == $past(len_q) + LEN_W'(1))
    else $error("stored length did not advance on an append");

endmodule

`default_nettype wire
